// ===== rtl/bounded_deque_with_search_top_macros.svh =====
// Assertion macros for the deque block.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define BDQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned ST_W         = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd4;

  // Operation applied to every cell of the chain in the same cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [DATA_W-1:0]   value;
  } cell_ctl_t;

  typedef struct packed {
    logic                empty;
    logic                full;
    logic [DATA_W-1:0]   head_data;
  } chain_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bdq_cell.sv =====
`default_nettype none

module bdq_cell import bdq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic [DATA_W-1:0] head_data_i,
  input  wire logic [DATA_W-1:0] prev_data_i,
  input  wire logic              prev_valid_i,
  input  wire logic [DATA_W-1:0] next_data_i,
  input  wire logic              next_valid_i,
  output logic      [DATA_W-1:0] data_o,
  output logic                   valid_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic              valid_q, valid_d;

  // Work out this cell's next word from its neighbours, the push word or the front word
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctl_i.op)
      OP_PUSH_FRONT: begin
        data_d  = prev_data_i;
        valid_d = prev_valid_i;
      end
      OP_PUSH_REAR: begin
        if (prev_valid_i && !valid_q) begin
          data_d  = ctl_i.value;
          valid_d = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        data_d  = next_data_i;
        valid_d = next_valid_i;
      end
      OP_ROTATE: begin
        // the last valid cell takes the front word, the other valid cells move one place forward
        if (valid_q) begin
          data_d = next_valid_i ? next_data_i : head_data_i;
        end
      end
      default: begin
        data_d  = data_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
`default_nettype none

module bdq_ctrl import bdq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [DATA_W-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [ST_W-1:0]   status_o,
  output logic      [DATA_W-1:0] data_o,
  output logic                   last_o,
  input  wire chain_sts_t        sts_i,
  output cell_ctl_t              ctl_o,
  output logic      [CW-1:0]     count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_PEND = 2'd2;

  localparam logic [1:0] M_LIST   = 2'd0;
  localparam logic [1:0] M_SEARCH = 2'd1;
  localparam logic [1:0] M_POPR   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [1:0]        mode_q, mode_d;
  logic [CW-1:0]     walk_q, walk_d;
  logic [CW-1:0]     count_q, count_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic              found_q, found_d;
  logic [ST_W-1:0]   pend_status_q, pend_status_d;
  logic [DATA_W-1:0] pend_data_q, pend_data_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_status_q, out_status_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              out_free;
  logic              accept;
  logic              match;
  logic              res_vld;
  logic [ST_W-1:0]   res_status;
  logic [DATA_W-1:0] res_data;
  logic              res_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign match      = (sts_i.head_data == key_q);

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    walk_d        = walk_q;
    count_d       = count_q;
    key_d         = key_q;
    found_d       = found_q;
    pend_status_d = pend_status_q;
    pend_data_d   = pend_data_q;
    out_status_d  = out_status_q;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    out_valid_d   = out_valid_q && out_stall_i;
    ctl_o.op      = OP_HOLD;
    ctl_o.value   = value_i;
    res_vld       = 1'b0;
    res_status    = ST_OK;
    res_data      = '0;
    res_last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        // decode the command word
        if (accept) begin
          case (command_i)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              res_vld = 1'b1;
              if (sts_i.full) begin
                res_status = ST_FULL;
              end else begin
                ctl_o.op = (command_i == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                count_d  = count_q + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              res_vld = 1'b1;
              if (sts_i.empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctl_o.op = OP_POP_FRONT;
                res_data = sts_i.head_data;
                count_d  = count_q - CW'(1);
              end
            end
            CMD_POP_REAR: begin
              if (sts_i.empty) begin
                res_vld    = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_d = S_WALK;
                mode_d  = M_POPR;
                walk_d  = count_q - CW'(1);
              end
            end
            CMD_LIST, CMD_SEARCH: begin
              if (sts_i.empty) begin
                res_vld    = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_d = S_WALK;
                mode_d  = (command_i == CMD_LIST) ? M_LIST : M_SEARCH;
                walk_d  = count_q;
                key_d   = value_i;
                found_d = 1'b0;
              end
            end
            default: begin
              res_vld = 1'b0;
            end
          endcase
        end
      end

      S_WALK: begin
        case (mode_q)
          M_LIST: begin
            // emit the front word and rotate, one word per free output slot
            if (out_free) begin
              ctl_o.op = OP_ROTATE;
              res_vld  = 1'b1;
              res_data = sts_i.head_data;
              res_last = (walk_q == CW'(1));
              walk_d   = walk_q - CW'(1);
              if (walk_q == CW'(1)) begin
                state_d = S_IDLE;
              end
            end
          end
          M_SEARCH: begin
            // compare the front word, rotate until the order is restored
            ctl_o.op = OP_ROTATE;
            found_d  = found_q | match;
            walk_d   = walk_q - CW'(1);
            if (walk_q == CW'(1)) begin
              res_vld    = 1'b1;
              res_status = (found_q || match) ? ST_FOUND : ST_NOT_FOUND;
              res_data   = key_q;
              state_d    = S_IDLE;
            end
          end
          M_POPR: begin
            // bring the rear word to the front, then drop it
            if (walk_q == '0) begin
              ctl_o.op = OP_POP_FRONT;
              res_vld  = 1'b1;
              res_data = sts_i.head_data;
              count_d  = count_q - CW'(1);
              state_d  = S_IDLE;
            end else begin
              ctl_o.op = OP_ROTATE;
              walk_d   = walk_q - CW'(1);
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_PEND: begin
        // hand the held result to the output register
        if (out_free) begin
          res_vld    = 1'b1;
          res_status = pend_status_q;
          res_data   = pend_data_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // place a result in the output register, or hold it until there is room
    if (res_vld) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_status_d = res_status;
        out_data_d   = res_data;
        out_last_d   = res_last;
      end else begin
        pend_status_d = res_status;
        pend_data_d   = res_data;
        state_d       = S_PEND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_LIST;
      walk_q      <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      walk_q      <= walk_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    pend_status_q <= pend_status_d;
    pend_data_q   <= pend_data_d;
    out_status_q  <= out_status_d;
    out_data_q    <= out_data_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;
  assign count_o     = count_q;

endmodule

`default_nettype wire

// ===== rtl/bounded_deque_with_search_top.sv =====
// Push, pop front and commands on an empty queue: result registered on accept, or held while the output stalls.
// Pop rear: rotating the cell chain one place a cycle until the rear word is at the front, then popping it.
// List: N results, one a cycle while the output is free; search: one result once the chain is back in order.
// A new command is taken once the previous one has placed its last result in the output register.
// Reset clears the cell valid bits, the count and the control; stored words need no clearing.
`default_nettype none

`include "bounded_deque_with_search_top_macros.svh"

module bounded_deque_with_search_top import bdq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic        [CMD_W-1:0]  command_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic             [ST_W-1:0]   status_o,
  output logic signed      [DATA_W-1:0] data_o,
  output logic                          last_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cell_ctl_t         ctl;
  chain_sts_t        sts;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] data_raw;

  bdq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     ($unsigned(value_i)),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_raw),
    .last_o      (last_o),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .count_o     (count)
  );

  assign data_o = $signed(data_raw);

  // Build the chain: the front cell sees the push word, the rear cell an empty neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_data, next_data;
    logic              prev_valid, next_valid;

    if (i == 0) begin : g_front
      assign prev_data  = ctl.value;
      assign prev_valid = 1'b1;
    end else begin : g_mid_prev
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_rear
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid_next
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .head_data_i  (cell_data[0]),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i])
    );
  end

  assign sts.empty     = !cell_valid[0];
  assign sts.full      = cell_valid[CAPACITY-1];
  assign sts.head_data = cell_data[0];

  // The held entries always fill the chain from the front, and the count tracks them
  `BDQ_ASSERT(a_count_matches, $countones(cell_valid) == count, "count differs from cells")
  `BDQ_ASSERT_NEVER(a_valid_gap, (cell_valid & (cell_valid + 1'b1)) != '0, "gap in cell chain")
  `BDQ_ASSERT(a_rotate_keeps_fill, ctl.op == OP_ROTATE |=> $stable(cell_valid),
              "rotation changed fill")

endmodule

`default_nettype wire

// ===== tb/tb_bounded_deque_with_search_top.sv =====
module tb_bounded_deque_with_search_top;
  import bdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 100;

  // Mix of commands favoured by the random sequences
  typedef enum int {MIX_FILL, MIX_DRAIN} deque_mix_e;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic              last;
  } deque_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_q = 1'b0;
  logic                     in_stall_o;
  logic        [CMD_W-1:0]  command_q = '0;
  logic signed [DATA_W-1:0] value_q = '0;
  logic                     out_valid_o;
  logic                     out_stall_q = 1'b0;
  logic        [ST_W-1:0]   status_o;
  logic signed [DATA_W-1:0] data_o;
  logic                     last_o;

  // Shadow copy of the deque
  logic [DATA_W-1:0] deque_ring [CAP];
  int                deque_head = 0;
  int                deque_count = 0;
  deque_result_t     pending_results [$];

  int  mismatches = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  bounded_deque_with_search_top #(.CAPACITY(CAP)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .command_i   (command_q),
    .value_i     (value_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void queue_result(input logic [ST_W-1:0] status,
                                       input logic [DATA_W-1:0] data, input logic last);
    deque_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // Apply one command to the shadow deque and queue the words it gives
  function automatic void predict_results(input logic [CMD_W-1:0] cmd,
                                          input logic [DATA_W-1:0] val);
    int  k;
    bit  hit;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (deque_count >= CAP) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            deque_head = (deque_head + CAP - 1) % CAP;
            deque_ring[deque_head] = val;
          end else begin
            deque_ring[(deque_head + deque_count) % CAP] = val;
          end
          deque_count++;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (deque_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else if (cmd == CMD_POP_FRONT) begin
          queue_result(ST_OK, deque_ring[deque_head], 1'b1);
          deque_head = (deque_head + 1) % CAP;
          deque_count--;
        end else begin
          queue_result(ST_OK, deque_ring[(deque_head + deque_count - 1) % CAP], 1'b1);
          deque_count--;
        end
      end
      CMD_LIST: begin
        if (deque_count == 0) queue_result(ST_EMPTY, '0, 1'b1);
        for (k = 0; k < deque_count; k++)
          queue_result(ST_OK, deque_ring[(deque_head + k) % CAP], k + 1 == deque_count);
      end
      CMD_SEARCH: begin
        hit = 1'b0;
        for (k = 0; k < deque_count; k++)
          if (deque_ring[(deque_head + k) % CAP] == val) hit = 1'b1;
        if (deque_count == 0) queue_result(ST_EMPTY, '0, 1'b1);
        else queue_result(hit ? ST_FOUND : ST_NOT_FOUND, val, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Predict on every accepted command, check every accepted result word
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni) begin
      if (in_valid_q && !in_stall_o) predict_results(command_q, value_q);
      if (out_valid_o && !out_stall_q) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word status %0d data %0d last %0b",
                                    status_o, data_o, last_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (data_o !== want.data)
            report_mismatch($sformatf("data %0d, want %0d", data_o, $signed(want.data)));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
    end
  end

  // Output stall: random, quiet, or a long counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_q <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_q <= 1'b1;
    end else if (out_quiet) begin
      out_stall_q <= 1'b0;
    end else begin
      out_stall_q <= ($urandom_range(99) < 17);
    end
  end

  // Offer one command word after a random gap and hold it until taken
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    while (!in_quiet && $urandom_range(99) < 17) begin
      in_valid_q <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    command_q  <= cmd;
    value_q    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the sender until every queued result has arrived
  task automatic pause_until_drained();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Random command with content; search keys often taken from held entries
  task automatic send_random(input deque_mix_e mix);
    int r;
    int push_lim;
    int pop_lim;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] val;
    r = $urandom_range(99);
    push_lim = (mix == MIX_FILL) ? 55 : 20;
    pop_lim  = (mix == MIX_FILL) ? 70 : 65;
    val = pick_value();
    if (r < push_lim) cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    else if (r < pop_lim) cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    else if (r < pop_lim + 10) cmd = CMD_LIST;
    else if (r < 96) begin
      cmd = CMD_SEARCH;
      if (deque_count > 0 && $urandom_range(1))
        val = deque_ring[(deque_head + $urandom_range(deque_count - 1)) % CAP];
    end else cmd = $urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
    send_word(cmd, val);
  endtask

  task automatic test_empty_queue();
    send_word(CMD_POP_FRONT, WORD_ONES);
    send_word(CMD_POP_REAR, WORD_MAX);
    send_word(CMD_LIST, WORD_MIN);
    send_word(CMD_SEARCH, '0);
    // undefined commands give nothing
    send_word(CMD_UNUSED_6, WORD_ONES);
    send_word(CMD_UNUSED_7, '0);
  endtask

  task automatic test_fill_and_full();
    int k;
    send_word(CMD_PUSH_REAR, WORD_MIN);
    send_word(CMD_PUSH_FRONT, WORD_MAX);
    send_word(CMD_PUSH_REAR, '0);
    send_word(CMD_PUSH_FRONT, WORD_ONES);
    send_word(CMD_SEARCH, WORD_MAX);
    send_word(CMD_SEARCH, 32'd1);
    for (k = 4; k < CAP; k++)
      send_word(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_REAR, $urandom);
    // full: both pushes refused
    send_word(CMD_PUSH_FRONT, 32'h1234_5678);
    send_word(CMD_PUSH_REAR, 32'h8765_4321);
    send_word(CMD_LIST, '0);
    send_word(CMD_SEARCH, deque_ring[(deque_head + CAP - 1) % CAP]);
  endtask

  task automatic test_random_mix(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      // stretch with no idling on either side
      in_quiet  = (k >= 100 && k < 160);
      out_quiet = in_quiet;
      send_random(((k / 40) % 2 == 0) ? MIX_DRAIN : MIX_FILL);
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  task automatic test_long_holdoff();
    int k;
    hold_req <= hold_req + 1;
    for (k = 0; k < 24; k++) send_random(MIX_FILL);
  endtask

  task automatic test_pause_then_resume();
    int k;
    pause_until_drained();
    for (k = 0; k < 30; k++) send_random(MIX_DRAIN);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_fill_and_full();
    test_random_mix(238);
    test_long_holdoff();
    test_pause_then_resume();
    pause_until_drained();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
